// ===== hw/rtl/mau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the matrix arithmetic unit
// Matrix size, fixed-point format, operation codes, sequencer states and the
// command record passed from the front end to the execution side.
// ----------------------------------------------------------------------------
package mau_pkg;

  // matrix geometry and number format
  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = $clog2(DIM);
  localparam int unsigned ELEMS     = DIM * DIM;
  localparam int unsigned ADDR_W    = $clog2(ELEMS);

  // multiply datapath widths
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(DIM);
  localparam int unsigned PRE_W  = ACC_W - FRAC_BITS;

  // command queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  // saturation limits
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // operation register codes
  typedef enum logic [1:0] {
    OP_MUL   = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUB   = 2'd2,
    OP_TRANS = 2'd3
  } mau_op_e;

  // store select of an input element
  typedef enum logic {
    KIND_LEFT  = 1'b0,
    KIND_RIGHT = 1'b1
  } mau_kind_e;

  // execution sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_EVAL
  } mau_state_e;

  // classified input item
  typedef struct packed {
    logic                 wr_left;
    logic                 wr_right;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_W-1:0]    value;
    logic                 start;
  } mau_cmd_t;

  // linear store address of element (row, col)
  function automatic logic [ADDR_W-1:0] mau_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
  endfunction

endpackage

// ===== hw/rtl/mau_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_in_if: element load channel
// Valid/ready channel carrying one matrix element and the start flag.
// ----------------------------------------------------------------------------
interface mau_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [mau_pkg::IDX_W-1:0]             first_index;
  logic [mau_pkg::IDX_W-1:0]             second_index;
  logic signed [mau_pkg::WORD_W-1:0]     element_value;
  logic                                  start_req;

  modport source (
    output valid, kind, first_index, second_index, element_value, start_req,
    input  ready
  );

  modport sink (
    input  valid, kind, first_index, second_index, element_value, start_req,
    output ready
  );
endinterface

// ===== hw/rtl/mau_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_out_if: result channel
// Valid/ready channel carrying one result element with its position and flags.
// ----------------------------------------------------------------------------
interface mau_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mau_pkg::IDX_W-1:0]             out_first_index;
  logic [mau_pkg::IDX_W-1:0]             out_second_index;
  logic signed [mau_pkg::WORD_W-1:0]     out_value;
  logic                                  saturated;
  logic                                  final_res;

  modport source (
    output valid, out_first_index, out_second_index, out_value, saturated, final_res,
    input  ready
  );

  modport sink (
    input  valid, out_first_index, out_second_index, out_value, saturated, final_res,
    output ready
  );
endinterface

// ===== hw/rtl/mau_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data registered and held when idle.
// ----------------------------------------------------------------------------
module mau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_front: input acceptance and classification
// Takes element transfers, checks the index range, picks the target store and
// pushes a command into the queue.
// ----------------------------------------------------------------------------
module mau_front (
  mau_in_if.sink              in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output mau_pkg::mau_cmd_t   push_cmd_o
);
  import mau_pkg::*;

  logic in_range;

  // elements outside the matrix are dropped but a start still runs
  assign in_range = (int'(in_i.first_index) < DIM) && (int'(in_i.second_index) < DIM);

  // command build
  always_comb begin
    push_cmd_o.wr_left  = in_range && (mau_kind_e'(in_i.kind) == KIND_LEFT);
    push_cmd_o.wr_right = in_range && (mau_kind_e'(in_i.kind) == KIND_RIGHT);
    push_cmd_o.addr     = mau_addr(in_i.first_index, in_i.second_index);
    push_cmd_o.value    = in_i.element_value;
    push_cmd_o.start    = in_i.start_req;
  end

  // handshake straight into the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ===== hw/rtl/mau_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_queue: command queue between front end and execution side
// Small register FIFO so loading can continue while a result matrix drains.
// ----------------------------------------------------------------------------
module mau_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  mau_pkg::mau_cmd_t   push_cmd_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output mau_pkg::mau_cmd_t   pop_cmd_o
);
  import mau_pkg::*;

  mau_cmd_t            entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/mau_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_back: execution side
// Writes the element stores, then on a start walks the result matrix: reads
// operands, multiplies and accumulates (multiply) or combines them directly,
// clamps and hands each element to the output register.
// ----------------------------------------------------------------------------
module mau_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  mau_pkg::mau_cmd_t   pop_cmd_i,
  mau_out_if.source           out_o
);
  import mau_pkg::*;

  mau_op_e            op_q;
  mau_state_e         state_q, state_d;

  logic [IDX_W-1:0]   row_q, col_q, k_q;
  logic               pop_fire, start_run;

  // sequencer strobes
  logic               rd_en, mul_en, acc_en, out_load;

  // store interface
  logic [ADDR_W-1:0]  l_raddr, r_raddr;
  logic [WORD_W-1:0]  l_rdata, r_rdata;

  // datapath
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PRE_W-1:0]  pre;
  logic [PRE_W-WORD_W:0]    pre_top;
  logic                     fits;
  logic [WORD_W-1:0]        res_val;
  logic                     res_sat;
  logic                     elem_last;

  // output register
  logic                     out_valid_q;
  logic                     out_free;
  logic [IDX_W-1:0]         out_first_q, out_second_q;
  logic [WORD_W-1:0]        out_value_q;
  logic                     out_sat_q, out_last_q;

  assign pop_fire  = pop_valid_i && pop_ready_o;
  assign start_run = pop_fire && pop_cmd_i.start;
  assign elem_last = (row_q == IDX_MAX) && (col_q == IDX_MAX);
  assign out_free  = !out_valid_q || out_o.ready;

  // operation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_MUL;
    end else if (cfg_we_i) begin
      op_q <= mau_op_e'(cfg_wdata_i);
    end
  end

  // element stores
  mau_ram #(.WIDTH(WORD_W), .DEPTH(ELEMS)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (pop_fire && pop_cmd_i.wr_left),
    .waddr_i (pop_cmd_i.addr),
    .wdata_i (pop_cmd_i.value),
    .re_i    (rd_en),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  mau_ram #(.WIDTH(WORD_W), .DEPTH(ELEMS)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (pop_fire && pop_cmd_i.wr_right),
    .waddr_i (pop_cmd_i.addr),
    .wdata_i (pop_cmd_i.value),
    .re_i    (rd_en),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // operand addresses
  always_comb begin
    unique case (op_q)
      OP_MUL: begin
        l_raddr = mau_addr(k_q, col_q);
        r_raddr = mau_addr(row_q, k_q);
      end
      OP_TRANS: begin
        l_raddr = mau_addr(col_q, row_q);
        r_raddr = mau_addr(row_q, col_q);
      end
      default: begin
        l_raddr = mau_addr(row_q, col_q);
        r_raddr = mau_addr(row_q, col_q);
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_run) state_d = ST_READ;
      ST_READ: state_d = (op_q == OP_MUL) ? ST_MUL : ST_EVAL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (k_q == IDX_MAX) ? ST_EVAL : ST_READ;
      ST_EVAL: begin
        if (out_free) begin
          state_d = elem_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_ready_o = 1'b0;
    rd_en       = 1'b0;
    mul_en      = 1'b0;
    acc_en      = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_ready_o = 1'b1;
      ST_READ: rd_en       = 1'b1;
      ST_MUL:  mul_en      = 1'b1;
      ST_ACC:  acc_en      = 1'b1;
      ST_EVAL: out_load    = out_free;
      default: pop_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // element and term counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      k_q   <= '0;
    end else begin
      if (start_run) begin
        row_q <= '0;
        col_q <= '0;
        k_q   <= '0;
      end
      if (acc_en) begin
        k_q <= (k_q == IDX_MAX) ? '0 : k_q + 1'b1;
      end
      if (out_load) begin
        col_q <= (col_q == IDX_MAX) ? '0 : col_q + 1'b1;
        if (col_q == IDX_MAX) begin
          row_q <= (row_q == IDX_MAX) ? '0 : row_q + 1'b1;
        end
      end
    end
  end

  // product and exact running sum
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= $signed(l_rdata) * $signed(r_rdata);
    end
    if (acc_en) begin
      acc_q <= ((k_q == '0) ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
    end
  end

  // value before clamping
  always_comb begin
    case (op_q)
      OP_MUL:  pre = PRE_W'(acc_q >>> FRAC_BITS);
      OP_ADD:  pre = PRE_W'($signed(l_rdata)) + PRE_W'($signed(r_rdata));
      OP_SUB:  pre = PRE_W'($signed(l_rdata)) - PRE_W'($signed(r_rdata));
      default: pre = PRE_W'($signed(l_rdata));
    endcase
  end

  // clamp to word range
  assign pre_top = pre[PRE_W-1:WORD_W-1];
  assign fits    = (&pre_top) || !(|pre_top);
  assign res_sat = !fits;
  assign res_val = fits ? pre[WORD_W-1:0] : (pre[PRE_W-1] ? WORD_MIN : WORD_MAX);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_first_q  <= row_q;
      out_second_q <= col_q;
      out_value_q  <= res_val;
      out_sat_q    <= res_sat;
      out_last_q   <= elem_last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_first_index  = out_first_q;
  assign out_o.out_second_index = out_second_q;
  assign out_o.out_value        = out_value_q;
  assign out_o.saturated        = out_sat_q;
  assign out_o.final_res        = out_last_q;

endmodule

// ===== hw/rtl/matrix4_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_arithmetic_unit: 4x4 Q16.16 matrix multiply / add / sub / transpose
// Usage:
//   in_i carries one element per transfer into the left or right store at
//   (first_index, second_index); indices outside the matrix are not stored.
//   A transfer with start_req stores its element, then runs the operation
//   held in the register written through cfg_we_i / cfg_wdata_i.
//   out_o returns 16 result elements, row by row, final_res on the last.
// Flow:
//   loads pass a two-entry command queue and are taken one per cycle while
//   the queue has room. after a start, multiply runs a store read, a multiply
//   and an accumulate for each product term, then clamps the element; add,
//   subtract and transpose read the stores and then clamp each element.
//   the single multiplier is reused for every product term, after a store read.
//   the first result is registered once its element is evaluated; loads keep
//   queueing meanwhile, up to two items.
// Reset clears the operation to multiply and empties the queue; the stores
// are not cleared. A stalled receiver holds the current result in the
// output register and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module matrix4_arithmetic_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  mau_in_if.sink        in_i,
  mau_out_if.source     out_o
);
  import mau_pkg::*;

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  mau_cmd_t  push_cmd, pop_cmd;

  // accept and classify
  mau_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // command queue
  mau_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // stores and arithmetic
  mau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/mau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_checker: port-level checks of the matrix arithmetic unit
// Watches the result channel and flags protocol or value slips.
// ----------------------------------------------------------------------------
module mau_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [mau_pkg::IDX_W-1:0]         out_first_i,
  input  logic [mau_pkg::IDX_W-1:0]         out_second_i,
  input  logic [mau_pkg::WORD_W-1:0]        out_value_i,
  input  logic                              out_sat_i,
  input  logic                              out_last_i
);
  import mau_pkg::*;

  // pending result is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_sat_i))
    else $error("result changed while stalled");

  // last flag only on the bottom-right element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> (out_first_i == IDX_MAX) && (out_second_i == IDX_MAX))
    else $error("final flag on wrong element");

  // a clamped result sits at one of the limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sat_i |-> (out_value_i == WORD_MAX) || (out_value_i == WORD_MIN))
    else $error("saturated result not at a limit");

endmodule

bind matrix4_arithmetic_unit mau_checker u_mau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_first_i  (out_o.out_first_index),
  .out_second_i (out_o.out_second_index),
  .out_value_i  (out_o.out_value),
  .out_sat_i    (out_o.saturated),
  .out_last_i   (out_o.final_res)
);
